// ===== hdl/detection_triggered_record_control_unit_macros.svh =====
// Assertion helpers shared by the record control design.
`ifndef DETECTION_TRIGGERED_RECORD_CONTROL_UNIT_MACROS_SVH
`define DETECTION_TRIGGERED_RECORD_CONTROL_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dtrc_pkg.sv =====
package dtrc_pkg;

    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int REASON_W = 2;
    localparam int INDEX_W  = 3;
    localparam int CFG_W    = 32;

    localparam logic [REASON_W-1:0] STOP_NONE = 2'd0;
    localparam logic [REASON_W-1:0] STOP_MAX  = 2'd1;
    localparam logic [REASON_W-1:0] STOP_GONE = 2'd2;

    localparam logic [INDEX_W-1:0] REG_DETECT_THRESHOLD = 3'd0;
    localparam logic [INDEX_W-1:0] REG_MAX_DURATION     = 3'd1;
    localparam logic [INDEX_W-1:0] REG_POST_DETECT_HOLD = 3'd2;
    localparam logic [INDEX_W-1:0] REG_MIN_DURATION     = 3'd3;

    localparam logic [COUNT_W-1:0] RST_DETECT_THRESHOLD = 8'd5;
    localparam logic [TIME_W-1:0]  RST_MAX_DURATION     = 32'd60000;
    localparam logic [TIME_W-1:0]  RST_POST_DETECT_HOLD = 32'd5000;
    localparam logic [TIME_W-1:0]  RST_MIN_DURATION     = 32'd10000;

    typedef struct packed {
        logic              face_seen;
        logic [TIME_W-1:0] now_ms;
    } dtrc_in_t;

    typedef struct packed {
        logic                start_pulse;
        logic                stop_pulse;
        logic [REASON_W-1:0] halt_cause;
        logic                rec_on;
    } dtrc_out_t;

    typedef struct packed {
        logic [COUNT_W-1:0] detect_threshold;
        logic [TIME_W-1:0]  max_duration_ms;
        logic [TIME_W-1:0]  post_detect_hold_ms;
        logic [TIME_W-1:0]  min_duration_ms;
    } dtrc_cfg_t;

    typedef struct packed {
        logic               recording_flag;
        logic [COUNT_W-1:0] detect_run_count;
        logic [TIME_W-1:0]  rec_begin_ms;
        logic [TIME_W-1:0]  last_detect_time;
    } dtrc_state_t;

endpackage

// ===== hdl/dtrc_step.sv =====
module dtrc_step
    import dtrc_pkg::*;
(
    input  dtrc_cfg_t   cfg,
    input  dtrc_state_t state,
    input  dtrc_in_t    item,
    output dtrc_state_t state_next,
    output dtrc_out_t   result
);

    always_comb
    begin
        logic [COUNT_W-1:0]  count_inc;
        logic                start;
        logic                active;
        logic [TIME_W-1:0]   start_time;
        logic [TIME_W-1:0]   last_time;
        logic [TIME_W-1:0]   dur;
        logic [TIME_W-1:0]   quiet;
        logic [REASON_W-1:0] reason;
        logic                stop;

        if (!item.face_seen)
        begin
            count_inc = '0;
        end
        else if (state.detect_run_count == {COUNT_W{1'b1}})
        begin
            count_inc = state.detect_run_count;
        end
        else
        begin
            count_inc = state.detect_run_count + COUNT_W'(1);
        end

        start      = item.face_seen && !state.recording_flag
                     && (count_inc >= cfg.detect_threshold);
        active     = state.recording_flag || start;
        start_time = start ? item.now_ms : state.rec_begin_ms;
        last_time  = item.face_seen ? item.now_ms : state.last_detect_time;
        dur        = item.now_ms - start_time;
        quiet      = item.now_ms - last_time;

        reason = STOP_NONE;
        if (active)
        begin
            if (dur >= cfg.max_duration_ms)
            begin
                reason = STOP_MAX;
            end
            else if (quiet >= cfg.post_detect_hold_ms && dur >= cfg.min_duration_ms)
            begin
                reason = STOP_GONE;
            end
        end
        stop = (reason != STOP_NONE);

        state_next.recording_flag    = active && !stop;
        state_next.detect_run_count  = (start || stop) ? '0 : count_inc;
        state_next.rec_begin_ms      = start_time;
        state_next.last_detect_time  = last_time;

        result.start_pulse = start;
        result.stop_pulse  = stop;
        result.halt_cause  = reason;
        result.rec_on      = active && !stop;
    end

endmodule

// ===== hdl/detection_triggered_record_control_unit.sv =====
// Detection-triggered record control.
// Input channel: in_valid, in_stall and in_data carry one beat per video frame,
// holding the face detection flag and the frame timestamp in milliseconds.
// Output channel: out_valid, out_stall and out_data carry one result beat per
// frame with the start and stop pulses, the stop reason and the recording flag.
// Configuration: cfg_write, cfg_index and cfg_data write the detection threshold
// and the maximum, hold and minimum durations; unknown indexes are ignored.
// A frame is taken into an input register, evaluated by one pass of compare and
// subtract logic and stored in a result register, from which its result beat is
// presented. One frame is accepted every cycle while in_stall is low, since
// the state update of a frame completes in the same cycle it is evaluated.
// Reset restores the default configuration, clears the recording flag, the
// detection run count and both stored times, and empties both registers.
// When the receiver stalls, the result beat holds; the input register still
// fills, and in_stall rises once both registers hold a beat while out_stall is high.
module detection_triggered_record_control_unit
    import dtrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  dtrc_in_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output dtrc_out_t          out_data,
    input  logic               cfg_write,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

`include "detection_triggered_record_control_unit_macros.svh"

    dtrc_cfg_t   cfg_reg;
    dtrc_cfg_t   cfg_next;
    dtrc_state_t state_reg;
    dtrc_state_t state_next;
    dtrc_in_t    in_data_reg;
    logic        in_valid_reg;
    dtrc_out_t   out_data_reg;
    dtrc_out_t   out_data_next;
    logic        out_valid_reg;
    logic        advance;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DETECT_THRESHOLD: cfg_next.detect_threshold    = cfg_data[COUNT_W-1:0];
                REG_MAX_DURATION:     cfg_next.max_duration_ms     = cfg_data[TIME_W-1:0];
                REG_POST_DETECT_HOLD: cfg_next.post_detect_hold_ms = cfg_data[TIME_W-1:0];
                REG_MIN_DURATION:     cfg_next.min_duration_ms     = cfg_data[TIME_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    dtrc_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (in_data_reg),
        .state_next (state_next),
        .result     (out_data_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_threshold    <= RST_DETECT_THRESHOLD;
            cfg_reg.max_duration_ms     <= RST_MAX_DURATION;
            cfg_reg.post_detect_hold_ms <= RST_POST_DETECT_HOLD;
            cfg_reg.min_duration_ms     <= RST_MIN_DURATION;
            state_reg                   <= '0;
            in_valid_reg                <= 1'b0;
            out_valid_reg               <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `DTRC_ASSERT_SAME(a_stop_ends_recording, out_valid_reg && out_data_reg.stop_pulse,
        !out_data_reg.rec_on, "A stop beat still reports recording.")
    `DTRC_ASSERT_SAME(a_reason_matches_stop, out_valid_reg,
        out_data_reg.stop_pulse == (out_data_reg.halt_cause != STOP_NONE),
        "Stop reason and stop pulse disagree.")
    `DTRC_ASSERT_SAME(a_start_sets_recording,
        out_valid_reg && out_data_reg.start_pulse && !out_data_reg.stop_pulse,
        out_data_reg.rec_on, "A start beat without a stop does not report recording.")
    `DTRC_ASSERT_NEXT(a_advance_fills_output, advance,
        out_valid_reg && out_data_reg.rec_on == state_reg.recording_flag,
        "An evaluated frame did not reach the result register.")
    `DTRC_ASSERT_SAME(a_empty_never_stalls, !in_valid_reg, !in_stall,
        "Input stalls while the input register is empty.")

endmodule
